// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL files of the I2C offset-access master
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define AST_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define AST_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// ----- design/i2cmoa_pkg.sv -----
// Types and codes shared by the I2C offset-access master modules
package i2cmoa_pkg;

  // Raw input item codes
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_BEGIN_WR = 2'd1;
  localparam logic [1:0] KIND_BEGIN_RD = 2'd2;
  localparam logic [1:0] KIND_SUPPLY   = 2'd3;

  // Transaction status codes
  localparam logic [2:0] STAT_OK           = 3'd0;
  localparam logic [2:0] STAT_ADDR_NACK    = 3'd1;
  localparam logic [2:0] STAT_OFFSET_NACK  = 3'd2;
  localparam logic [2:0] STAT_DATA_NACK    = 3'd3;
  localparam logic [2:0] STAT_RESTART_NACK = 3'd4;

  // Bits in one byte slot before the ACK bit
  localparam logic [3:0] ACK_SLOT = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  slave_addr;
    logic [15:0] offset;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       last_read;
    logic       byte_wanted;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_BEGIN_WR,
    CMD_BEGIN_RD,
    CMD_SUPPLY
  } cmd_t;

  // Classified command as it sits in the queue
  typedef struct packed {
    cmd_t        cmd;
    logic [6:0]  slave_addr;
    logic [15:0] offset;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        sda_in;
  } q_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_START   = 4'd1,
    ST_ADDR    = 4'd2,
    ST_OFFH    = 4'd3,
    ST_OFFL    = 4'd4,
    ST_WAIT    = 4'd5,
    ST_WDATA   = 4'd6,
    ST_RESTART = 4'd7,
    ST_RADDR   = 4'd8,
    ST_RDATA   = 4'd9,
    ST_STOP    = 4'd10
  } seq_state_t;

endpackage

// ----- design/i2cmoa_front.sv -----
// Front end: accepts input beats, classifies them and queues them for the sequencer
`include "assert_macros.svh"

module i2cmoa_front
  import i2cmoa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output q_entry_t q_head,
  input  logic     q_pop
);

  q_entry_t   ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  q_entry_t   cls;

  // Classify the incoming beat
  always_comb begin
    cls.slave_addr = in_data.slave_addr;
    cls.offset     = in_data.offset;
    cls.byte_count = in_data.byte_count;
    cls.write_byte = in_data.write_byte;
    cls.sda_in     = in_data.sda_in;
    case (in_data.kind)
      KIND_TICK:     cls.cmd = CMD_TICK;
      KIND_BEGIN_WR: cls.cmd = CMD_BEGIN_WR;
      KIND_BEGIN_RD: cls.cmd = CMD_BEGIN_RD;
      KIND_SUPPLY:   cls.cmd = CMD_SUPPLY;
      default:       cls.cmd = CMD_TICK;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = ent_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified beat
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

  `AST_NEVER(a_cnt_range, clk, rst_n, cnt_r == 2'd3, "queue count out of range")
  `AST_ALWAYS(a_pop_nonempty, clk, rst_n, q_pop |-> (cnt_r != 2'd0), "pop from empty queue")
  `AST_ALWAYS(a_empty_ptrs, clk, rst_n, (cnt_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r), "empty queue with split pointers")

endmodule

// ----- design/i2cmoa_back.sv -----
// Back end: bus phase sequencer and result register
`include "assert_macros.svh"

module i2cmoa_back
  import i2cmoa_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = COUNT_WIDTH;

  seq_state_t    state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [3:0]    bidx_r, bidx_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [6:0]    dev_r, dev_nxt;
  logic [15:0]   off_r, off_nxt;
  logic          is_rd_r, is_rd_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [2:0]    status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          step;
  logic          rvalid, rlast, done;
  logic [7:0]    rbyte;
  logic [CW-1:0] left_dec;
  logic [CW-1:0] cnt_load;
  logic [CW+15:0] cnt_ext;
  logic [7:0]    rd_shift;
  logic          scl, sdl;

  // Take one beat whenever the result register is free or being drained
  assign step     = q_valid && (!out_valid_r || out_ready);
  assign q_pop    = step;
  assign left_dec = left_r - CW'(1);
  assign cnt_ext  = {{CW{1'b0}}, q_head.byte_count};
  assign cnt_load = cnt_ext[CW-1:0];
  assign rd_shift = {shift_r[6:0], q_head.sda_in};

  // Next state of the sequencer
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    bidx_nxt   = bidx_r;
    shift_nxt  = shift_r;
    left_nxt   = left_r;
    dev_nxt    = dev_r;
    off_nxt    = off_r;
    is_rd_nxt  = is_rd_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    status_nxt = status_r;
    rvalid     = 1'b0;
    rbyte      = 8'd0;
    rlast      = 1'b0;
    done       = 1'b0;
    if (step) begin
      case (q_head.cmd)
        CMD_BEGIN_WR, CMD_BEGIN_RD: begin
          if (state_r == ST_IDLE) begin
            dev_nxt    = q_head.slave_addr;
            off_nxt    = q_head.offset;
            left_nxt   = cnt_load;
            is_rd_nxt  = (q_head.cmd == CMD_BEGIN_RD);
            pend_v_nxt = 1'b0;
            status_nxt = STAT_OK;
            state_nxt  = ST_START;
            phase_nxt  = 2'd2;
            bidx_nxt   = 4'd0;
            shift_nxt  = 8'd0;
          end
        end
        CMD_SUPPLY: begin
          if (state_r == ST_WAIT) begin
            state_nxt = ST_WDATA;
            shift_nxt = q_head.write_byte;
            bidx_nxt  = 4'd0;
            phase_nxt = 2'd0;
          end else if (state_r != ST_IDLE && !is_rd_r) begin
            pend_nxt   = q_head.write_byte;
            pend_v_nxt = 1'b1;
          end
        end
        CMD_TICK: begin
          case (state_r)
            ST_START, ST_RESTART: begin
              if (phase_r != 2'd3) begin
                phase_nxt = phase_r + 2'd1;
              end else begin
                state_nxt = (state_r == ST_START) ? ST_ADDR : ST_RADDR;
                shift_nxt = {dev_r, (state_r == ST_RESTART)};
                bidx_nxt  = 4'd0;
                phase_nxt = 2'd0;
              end
            end
            ST_ADDR, ST_OFFH, ST_OFFL, ST_WDATA, ST_RADDR: begin
              if (phase_r == 2'd0) begin
                phase_nxt = 2'd1;
              end else if (phase_r == 2'd1) begin
                if (bidx_r == ACK_SLOT) begin
                  shift_nxt = {7'd0, q_head.sda_in};
                end
                phase_nxt = 2'd2;
              end else if (bidx_r < ACK_SLOT) begin
                bidx_nxt  = bidx_r + 4'd1;
                phase_nxt = 2'd0;
              end else if (shift_r[0]) begin
                // Device NACK: record the cause and stop
                case (state_r)
                  ST_ADDR:  status_nxt = STAT_ADDR_NACK;
                  ST_WDATA: status_nxt = STAT_DATA_NACK;
                  ST_RADDR: status_nxt = STAT_RESTART_NACK;
                  default:  status_nxt = STAT_OFFSET_NACK;
                endcase
                state_nxt = ST_STOP;
                phase_nxt = 2'd0;
              end else begin
                case (state_r)
                  ST_ADDR: begin
                    state_nxt = ST_OFFH;
                    shift_nxt = off_r[15:8];
                    bidx_nxt  = 4'd0;
                    phase_nxt = 2'd0;
                  end
                  ST_OFFH: begin
                    state_nxt = ST_OFFL;
                    shift_nxt = off_r[7:0];
                    bidx_nxt  = 4'd0;
                    phase_nxt = 2'd0;
                  end
                  ST_RADDR: begin
                    phase_nxt = 2'd0;
                    if (left_r == '0) begin
                      state_nxt = ST_STOP;
                    end else begin
                      state_nxt = ST_RDATA;
                      shift_nxt = 8'd0;
                      bidx_nxt  = 4'd0;
                    end
                  end
                  default: begin
                    // Offset low or data byte done: restart for a read, else pick the next write step
                    if (state_r == ST_WDATA) begin
                      left_nxt = left_dec;
                    end
                    phase_nxt = 2'd0;
                    if (state_r == ST_OFFL && is_rd_r) begin
                      state_nxt = ST_RESTART;
                    end else if (left_nxt == '0) begin
                      state_nxt = ST_STOP;
                    end else if (pend_v_r) begin
                      pend_v_nxt = 1'b0;
                      state_nxt  = ST_WDATA;
                      shift_nxt  = pend_r;
                      bidx_nxt   = 4'd0;
                    end else begin
                      state_nxt = ST_WAIT;
                    end
                  end
                endcase
              end
            end
            ST_RDATA: begin
              if (phase_r == 2'd0) begin
                phase_nxt = 2'd1;
              end else if (phase_r == 2'd1) begin
                if (bidx_r < ACK_SLOT) begin
                  shift_nxt = rd_shift;
                  if (bidx_r == 4'd7) begin
                    rvalid = 1'b1;
                    rbyte  = rd_shift;
                    rlast  = (left_r == CW'(1));
                  end
                end
                phase_nxt = 2'd2;
              end else if (bidx_r < ACK_SLOT) begin
                bidx_nxt  = bidx_r + 4'd1;
                phase_nxt = 2'd0;
              end else begin
                left_nxt  = left_dec;
                phase_nxt = 2'd0;
                if (left_dec == '0) begin
                  state_nxt = ST_STOP;
                end else begin
                  state_nxt = ST_RDATA;
                  shift_nxt = 8'd0;
                  bidx_nxt  = 4'd0;
                end
              end
            end
            ST_STOP: begin
              if (phase_r != 2'd2 && phase_r != 2'd3) begin
                phase_nxt = phase_r + 2'd1;
              end else begin
                state_nxt = ST_IDLE;
                phase_nxt = 2'd0;
                done      = 1'b1;
              end
            end
            ST_WAIT: begin
              // Hold SCL low until the byte arrives
            end
            default: begin
              state_nxt = ST_IDLE;
              phase_nxt = 2'd0;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Bus drive levels that hold after this beat
  always_comb begin
    scl = 1'b0;
    sdl = 1'b0;
    case (state_nxt)
      ST_START, ST_RESTART: begin
        scl = (phase_nxt == 2'd0) || (phase_nxt == 2'd3);
        sdl = phase_nxt[1];
      end
      ST_ADDR, ST_OFFH, ST_OFFL, ST_WDATA, ST_RADDR: begin
        scl = (phase_nxt != 2'd1);
        if (bidx_nxt < ACK_SLOT) begin
          sdl = ~shift_nxt[3'(3'd7 - bidx_nxt[2:0])];
        end
      end
      ST_RDATA: begin
        scl = (phase_nxt != 2'd1);
        sdl = (bidx_nxt == ACK_SLOT) && (left_nxt > CW'(1));
      end
      ST_WAIT: begin
        scl = 1'b1;
      end
      ST_STOP: begin
        scl = (phase_nxt == 2'd0);
        sdl = !phase_nxt[1];
      end
      default: begin
      end
    endcase
  end

  // Build the result beat
  always_comb begin
    out_data_nxt.scl_low     = scl;
    out_data_nxt.sda_low     = sdl;
    out_data_nxt.read_byte   = rbyte;
    out_data_nxt.read_valid  = rvalid;
    out_data_nxt.last_read   = rlast;
    out_data_nxt.byte_wanted = (state_nxt == ST_WAIT);
    out_data_nxt.busy_res    = (state_nxt != ST_IDLE);
    out_data_nxt.done_res    = done;
    out_data_nxt.status      = status_nxt;
    out_valid_nxt            = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 2'd0;
      bidx_r      <= 4'd0;
      left_r      <= '0;
      is_rd_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      status_r    <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      bidx_r      <= bidx_nxt;
      left_r      <= left_nxt;
      is_rd_r     <= is_rd_nxt;
      pend_v_r    <= pend_v_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    dev_r   <= dev_nxt;
    off_r   <= off_nxt;
    pend_r  <= pend_nxt;
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `AST_ALWAYS(a_bidx_range, clk, rst_n, bidx_r <= ACK_SLOT, "bit index past ACK slot")
  `AST_ALWAYS(a_wait_no_pend, clk, rst_n, (state_r == ST_WAIT) |-> !pend_v_r, "waiting with a pending byte")
  `AST_ALWAYS(a_idle_phase, clk, rst_n, (state_r == ST_IDLE) |-> (phase_r == 2'd0), "idle with nonzero phase")

endmodule

// ----- design/i2c_master_offset_access.sv -----
// Top level of the I2C master with 16-bit offset access
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_item_t  (tick, begin, write byte)
//   out_     out  out_valid/out_ready  out_item_t (bus drive levels, status)
//
// Every input beat yields one result beat; one beat per cycle is sustained
// while out_ready stays high. A beat passes through the two-entry command
// queue and then the sequencer, whose result register feeds the out_ channel.
// The sequencer's single bus phase step per beat sets the rate.
// Reset is synchronous, active low, and returns the bus to idle.
// A stalled out_ channel fills the queue and then drops in_ready.
module i2c_master_offset_access
  import i2cmoa_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;

  i2cmoa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  i2cmoa_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
